/* src/gcns_pkg.sv */
// Shared types and constants of the grid cell neighbor search block.
package gcns_pkg;

   localparam int POS_W  = 16;
   localparam int IDX_W  = 6;
   localparam int CSR_W  = 16;
   localparam int GDIM_W = 5;

   // Opcodes of a request transaction
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   // Result kinds of a response transaction
   localparam logic [1:0] KIND_DONE  = 2'd0;
   localparam logic [1:0] KIND_NEIGH = 2'd1;
   localparam logic [1:0] KIND_NONE  = 2'd2;
   localparam logic [1:0] KIND_FULL  = 2'd3;

   // Configuration register indexes
   localparam logic [0:0] REG_INV_CELL = 1'd0;
   localparam logic [0:0] REG_GRID_DIM = 1'd1;

   localparam logic [CSR_W-1:0]  INV_CELL_RESET = 16'd256;
   localparam logic [GDIM_W-1:0] GRID_DIM_RESET = 5'd16;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_MUL_Z,
      ST_MUL_G2,
      ST_NB_CHECK,
      ST_KEY_Y,
      ST_KEY_Z,
      ST_HEAD_RD,
      ST_HEAD_USE,
      ST_WALK,
      ST_WALK_USE,
      ST_NB_NEXT,
      ST_EMIT
   } state_type;

endpackage

/* src/gcns_if.sv */
// Request and response channel interfaces of the grid cell neighbor search block.
interface gcns_req_if import gcns_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       opcode;
   logic [POS_W-1:0] pos_x;
   logic [POS_W-1:0] pos_y;
   logic [POS_W-1:0] pos_z;
   logic [IDX_W-1:0] particle_index;

   modport source (output valid, opcode, pos_x, pos_y, pos_z, particle_index, input ready);
   modport sink   (input valid, opcode, pos_x, pos_y, pos_z, particle_index, output ready);
endinterface

interface gcns_rsp_if import gcns_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       result_kind;
   logic [IDX_W-1:0] neighbour_index;
   logic             last;

   modport source (output valid, result_kind, neighbour_index, last, input ready);
   modport sink   (input valid, result_kind, neighbour_index, last, output ready);
endinterface

/* src/gcns_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module gcns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read one entry per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/grid_cell_neighbour_search.sv */
// Uniform grid cell list: insert, neighbor query and clear over a shared multiplier.
//
// Usage: a request transaction carries an opcode, a Q8.8 position and a particle index.
// Insert maps the position to a cell and pushes the index onto that cell's bucket.
// Query visits the 27 surrounding cells (x outermost, z innermost) and returns one
// response transaction per stored index, newest first within a cell, with last set on
// the final one, or one "none found" transaction. Clear empties every bucket.
// Insert, clear and unused opcodes return one "done" transaction ("full" if the store
// is full). The user writes the reciprocal cell size and the grid side over the CSR
// port only while idle; the block itself does not enforce it. A single 16x16
// multiplier computes the three cell coordinates, the square of the side and two
// products per cell key. Clear sweeps all GRID_MAX^3 bucket heads, one per cycle.
// One request is in flight at a time; req ready is low while it is worked on.
// Reset starts the same sweep over all bucket heads; no request is taken until it ends.
// A stalled receiver holds the response register and pauses the walk.
module grid_cell_neighbour_search import gcns_pkg::*; #(
   parameter int MAX_POINTS = 64,
   parameter int GRID_MAX   = 16
) (
   input  logic              clock,
   input  logic              reset,
   gcns_req_if.sink          req_ch,
   gcns_rsp_if.source        rsp_ch,
   input  logic              csr_we,
   input  logic [0:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   localparam int CELLS = GRID_MAX * GRID_MAX * GRID_MAX;
   localparam int CW    = $clog2(GRID_MAX);
   localparam int GW    = $clog2(GRID_MAX + 1);
   localparam int G2W   = 2 * GW;
   localparam int NW    = CW + 2;
   localparam int KW    = $clog2(CELLS);
   localparam int EW    = $clog2(MAX_POINTS + 1);
   localparam int AW    = $clog2(MAX_POINTS);
   localparam logic [1:0] OFF_LAST = 2'd2;

   state_type state_ff, state_in;

   logic [CSR_W-1:0]  inv_ff, inv_in;
   logic [GDIM_W-1:0] gdim_ff, gdim_in;
   logic [1:0]        op_ff, op_in;
   logic [POS_W-1:0]  px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic [IDX_W-1:0]  pidx_ff, pidx_in;
   logic [CW-1:0]     cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [CW-1:0]     nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in;
   logic [G2W-1:0]    g2_ff, g2_in;
   logic [1:0]        dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [KW-1:0]     acc_ff, acc_in, key_ff, key_in, clr_cnt_ff, clr_cnt_in;
   logic [EW-1:0]     link_ff, link_in, used_ff, used_in;
   logic [1:0]        kind_ff, kind_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]  pend_ff, pend_in;
   logic              clr_op_ff, clr_op_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;
   logic [IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [GW-1:0]          g, g_m1;
   logic [POS_W-1:0]       mul_a, mul_b;
   logic [2*POS_W-1:0]     mul_p;
   logic [POS_W-1:0]       prod_hi;
   logic [CW-1:0]          cell_val;
   logic [NW-1:0]          xs, ys, zs, xm, ym, zm;
   logic                   in_rng;
   logic                   rsp_free;
   logic                   head_we;
   logic [KW-1:0]          head_waddr;
   logic [EW-1:0]          head_wdata, head_rd;
   logic                   ent_we;
   logic [EW+IDX_W-1:0]    ent_rd;
   logic [EW-1:0]          link_m1;
   logic                   full;

   // Effective grid side: zero acts as one, above the maximum acts as the maximum
   always_comb begin
      if (gdim_ff == '0) begin
         g = GW'(1);
      end else if (32'(gdim_ff) > 32'(GRID_MAX)) begin
         g = GW'(GRID_MAX);
      end else begin
         g = GW'(gdim_ff);
      end
   end
   assign g_m1 = g - 1'b1;

   // Shared multiplier operand select
   always_comb begin
      case (state_ff)
         ST_MUL_X: begin
            mul_a = px_ff;
            mul_b = inv_ff;
         end
         ST_MUL_Y: begin
            mul_a = py_ff;
            mul_b = inv_ff;
         end
         ST_MUL_Z: begin
            mul_a = pz_ff;
            mul_b = inv_ff;
         end
         ST_MUL_G2: begin
            mul_a = POS_W'(g);
            mul_b = POS_W'(g);
         end
         ST_KEY_Y: begin
            mul_a = POS_W'(ny_ff);
            mul_b = POS_W'(g);
         end
         ST_KEY_Z: begin
            mul_a = POS_W'(nz_ff);
            mul_b = POS_W'(g2_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p   = mul_a * mul_b;
   assign prod_hi = mul_p[2*POS_W-1:POS_W];

   // Clamp the scaled coordinate to the grid
   assign cell_val = (prod_hi >= POS_W'(g)) ? g_m1[CW-1:0] : prod_hi[CW-1:0];

   // Neighbor coordinates, offset by one so that zero means "below the grid"
   assign xs = NW'(cx_ff) + NW'(dx_ff);
   assign ys = NW'(cy_ff) + NW'(dy_ff);
   assign zs = NW'(cz_ff) + NW'(dz_ff);
   assign xm = xs - 1'b1;
   assign ym = ys - 1'b1;
   assign zm = zs - 1'b1;
   assign in_rng = (xs != '0) && (xs <= NW'(g)) && (ys != '0) && (ys <= NW'(g))
                && (zs != '0) && (zs <= NW'(g));

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign full     = 32'(used_ff) >= 32'(MAX_POINTS);
   assign link_m1  = link_ff - 1'b1;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (32'(clr_cnt_ff) == 32'(CELLS - 1)) begin
               state_in = clr_op_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_MUL_X;
            end
         end
         ST_MUL_X: state_in = ST_MUL_Y;
         ST_MUL_Y: state_in = ST_MUL_Z;
         ST_MUL_Z: state_in = ST_MUL_G2;
         ST_MUL_G2: begin
            case (op_ff)
               OP_INSERT: state_in = full ? ST_EMIT : ST_KEY_Y;
               OP_QUERY:  state_in = ST_NB_CHECK;
               OP_CLEAR:  state_in = ST_CLEAR;
               default:   state_in = ST_EMIT;
            endcase
         end
         ST_NB_CHECK: state_in = in_rng ? ST_KEY_Y : ST_NB_NEXT;
         ST_KEY_Y:    state_in = ST_KEY_Z;
         ST_KEY_Z:    state_in = ST_HEAD_RD;
         ST_HEAD_RD:  state_in = ST_HEAD_USE;
         ST_HEAD_USE: state_in = (op_ff == OP_INSERT) ? ST_EMIT : ST_WALK;
         ST_WALK:     state_in = (link_ff == '0) ? ST_NB_NEXT : ST_WALK_USE;
         ST_WALK_USE: begin
            if (!pend_valid_ff || rsp_free) begin
               state_in = ST_WALK;
            end
         end
         ST_NB_NEXT: begin
            if (dx_ff == OFF_LAST && dy_ff == OFF_LAST && dz_ff == OFF_LAST) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_NB_CHECK;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      inv_in        = inv_ff;
      gdim_in       = gdim_ff;
      op_in         = op_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      pz_in         = pz_ff;
      pidx_in       = pidx_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      cz_in         = cz_ff;
      nx_in         = nx_ff;
      ny_in         = ny_ff;
      nz_in         = nz_ff;
      g2_in         = g2_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      dz_in         = dz_ff;
      acc_in        = acc_ff;
      key_in        = key_ff;
      clr_cnt_in    = clr_cnt_ff;
      link_in       = link_ff;
      used_in       = used_ff;
      kind_in       = kind_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      clr_op_in     = clr_op_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_last_in   = rsp_last_ff;
      head_we       = 1'b0;
      head_waddr    = key_ff;
      head_wdata    = used_ff + 1'b1;
      ent_we        = 1'b0;

      // Take configuration writes at any time
      if (csr_we) begin
         case (csr_index)
            REG_INV_CELL: inv_in  = csr_wdata;
            REG_GRID_DIM: gdim_in = csr_wdata[GDIM_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            head_we    = 1'b1;
            head_waddr = clr_cnt_ff;
            head_wdata = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in         = req_ch.opcode;
               px_in         = req_ch.pos_x;
               py_in         = req_ch.pos_y;
               pz_in         = req_ch.pos_z;
               pidx_in       = req_ch.particle_index;
               pend_valid_in = 1'b0;
               dx_in         = '0;
               dy_in         = '0;
               dz_in         = '0;
            end
         end
         ST_MUL_X: cx_in = cell_val;
         ST_MUL_Y: cy_in = cell_val;
         ST_MUL_Z: cz_in = cell_val;
         ST_MUL_G2: begin
            g2_in = mul_p[G2W-1:0];
            nx_in = cx_ff;
            ny_in = cy_ff;
            nz_in = cz_ff;
            case (op_ff)
               OP_INSERT: kind_in = full ? KIND_FULL : KIND_DONE;
               OP_QUERY:  kind_in = KIND_NONE;
               OP_CLEAR: begin
                  kind_in    = KIND_DONE;
                  used_in    = '0;
                  clr_cnt_in = '0;
                  clr_op_in  = 1'b1;
               end
               default: kind_in = KIND_DONE;
            endcase
         end
         ST_NB_CHECK: begin
            nx_in = xm[CW-1:0];
            ny_in = ym[CW-1:0];
            nz_in = zm[CW-1:0];
         end
         ST_KEY_Y: acc_in = KW'(nx_ff) + mul_p[KW-1:0];
         ST_KEY_Z: key_in = acc_ff + mul_p[KW-1:0];
         ST_HEAD_USE: begin
            if (op_ff == OP_INSERT) begin
               head_we = 1'b1;
               ent_we  = 1'b1;
               used_in = used_ff + 1'b1;
            end else begin
               link_in = head_rd;
            end
         end
         ST_WALK_USE: begin
            // Hold one found index back so the final one can carry last
            if (!pend_valid_ff) begin
               pend_valid_in = 1'b1;
               pend_in       = ent_rd[IDX_W-1:0];
               link_in       = ent_rd[EW+IDX_W-1:IDX_W];
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_NEIGH;
               rsp_idx_in   = pend_ff;
               rsp_last_in  = 1'b0;
               pend_in      = ent_rd[IDX_W-1:0];
               link_in      = ent_rd[EW+IDX_W-1:IDX_W];
            end
         end
         ST_NB_NEXT: begin
            if (dz_ff != OFF_LAST) begin
               dz_in = dz_ff + 2'd1;
            end else begin
               dz_in = '0;
               if (dy_ff != OFF_LAST) begin
                  dy_in = dy_ff + 2'd1;
               end else begin
                  dy_in = '0;
                  dx_in = dx_ff + 2'd1;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pend_valid_ff ? KIND_NEIGH : kind_ff;
               rsp_idx_in   = pend_valid_ff ? pend_ff : '0;
               rsp_last_in  = 1'b1;
               clr_op_in    = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         inv_ff        <= INV_CELL_RESET;
         gdim_ff       <= GRID_DIM_RESET;
         used_ff       <= '0;
         clr_cnt_ff    <= '0;
         clr_op_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         inv_ff        <= inv_in;
         gdim_ff       <= gdim_in;
         used_ff       <= used_in;
         clr_cnt_ff    <= clr_cnt_in;
         clr_op_ff     <= clr_op_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      pz_ff       <= pz_in;
      pidx_ff     <= pidx_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      nz_ff       <= nz_in;
      g2_ff       <= g2_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      dz_ff       <= dz_in;
      acc_ff      <= acc_in;
      key_ff      <= key_in;
      link_ff     <= link_in;
      kind_ff     <= kind_in;
      pend_ff     <= pend_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Bucket heads: entry number plus one, zero for an empty cell
   gcns_ram #(
      .WIDTH (EW),
      .DEPTH (CELLS)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_addr (key_ff),
      .rd_data (head_rd)
   );

   // Entry store: link to the next entry and the stored particle index
   gcns_ram #(
      .WIDTH (EW + IDX_W),
      .DEPTH (MAX_POINTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (used_ff[AW-1:0]),
      .wr_data ({head_rd, pidx_ff}),
      .rd_addr (link_m1[AW-1:0]),
      .rd_data (ent_rd)
   );

   assign req_ch.ready           = (state_ff == ST_IDLE);
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.result_kind     = rsp_kind_ff;
   assign rsp_ch.neighbour_index = rsp_idx_ff;
   assign rsp_ch.last            = rsp_last_ff;

endmodule

/* src/gcns_checker.sv */
// Port-level checks of the grid cell neighbor search block, bound to the top level.
module gcns_checker import gcns_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [1:0]       rsp_kind,
   input logic [IDX_W-1:0] rsp_index,
   input logic             rsp_last
);

   // Hold a stalled response transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_index)
                                  && $stable(rsp_last))
      else $error("stalled response changed");

   // Drop ready right after a request is taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // Only neighbor results may come without last
   a_mid_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_kind == KIND_NEIGH)
      else $error("non-final result is not a neighbor");

   // Other kinds are single, final and carry a zero index
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_NEIGH |-> rsp_last && rsp_index == '0)
      else $error("malformed single result");

endmodule

bind grid_cell_neighbour_search gcns_checker u_gcns_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_kind  (rsp_ch.result_kind),
   .rsp_index (rsp_ch.neighbour_index),
   .rsp_last  (rsp_ch.last)
);

/* tb/gcns_tb_if.sv */
`timescale 1ns / 100ps
// Checker-side view of the request and response channels of the grid cell neighbor search block.
interface gcns_mon_if import gcns_pkg::*; ();
   logic             req_fire;
   logic [1:0]       opcode;
   logic [POS_W-1:0] pos_x;
   logic [POS_W-1:0] pos_y;
   logic [POS_W-1:0] pos_z;
   logic [IDX_W-1:0] particle_index;
   logic             rsp_fire;
   logic [1:0]       result_kind;
   logic [IDX_W-1:0] neighbour_index;
   logic             last;
   logic             csr_we;
   logic [0:0]       csr_index;
   logic [CSR_W-1:0] csr_wdata;
endinterface

/* tb/gcns_checker.sv */
`timescale 1ns / 100ps
// Checker: predicts the grid cell neighbor search results and compares them with the block.
module gcns_scoreboard import gcns_pkg::*; #(
   parameter int MAX_POINTS = 64,
   parameter int GRID_MAX   = 16
) (
   input  logic       clock,
   input  logic       reset,
   gcns_mon_if        mon,
   output int         fail_count,
   output int         pending_count,
   output int         result_count
);

   typedef struct packed {
      logic [1:0]       kind;
      logic [IDX_W-1:0] index;
      logic             last;
   } result_type;

   localparam int CELLS = GRID_MAX * GRID_MAX * GRID_MAX;

   result_type     expected_q[$];
   logic [15:0]    inv_cell;
   logic [4:0]     grid_side_reg;
   logic [6:0]     head_of_cell[CELLS];
   logic [6:0]     link_of_entry[MAX_POINTS];
   logic [5:0]     value_of_entry[MAX_POINTS];
   int             entries_used;

   task automatic report(input string what, input result_type got, input result_type want);
      $display("%0t: mismatch %s: got kind %0d index %0d last %0d,", $time, what,
               got.kind, got.index, got.last);
      $display("   want kind %0d index %0d last %0d", want.kind, want.index, want.last);
      fail_count++;
   endtask

   // Append one expected result at the tail of the queue
   function automatic void queue_result(input result_type r);
      expected_q.insert(expected_q.size(), r);
   endfunction

   function automatic int side_in_use();
      int g;
      g = grid_side_reg;
      if (g == 0) g = 1;
      if (g > GRID_MAX) g = GRID_MAX;
      return g;
   endfunction

   function automatic int cell_coord(input logic [15:0] pos, input int g);
      longint c;
      c = (longint'(pos) * longint'(inv_cell)) >>> 16;
      if (c > g - 1) c = g - 1;
      return int'(c);
   endfunction

   // Apply one request transaction to the shadow store and queue its results
   task automatic predict_neighbours(input logic [1:0] op, input logic [15:0] px,
                                     input logic [15:0] py, input logic [15:0] pz,
                                     input logic [5:0] pidx);
      int g, cx, cy, cz, key, x, y, z, link, n;
      result_type r;
      g  = side_in_use();
      cx = cell_coord(px, g);
      cy = cell_coord(py, g);
      cz = cell_coord(pz, g);
      r  = '{KIND_DONE, '0, 1'b1};
      if (op == OP_INSERT) begin
         key = cx + cy * g + cz * g * g;
         if (entries_used >= MAX_POINTS || key >= CELLS) begin
            r.kind = KIND_FULL;
         end else begin
            value_of_entry[entries_used] = pidx;
            link_of_entry[entries_used]  = head_of_cell[key];
            head_of_cell[key]            = 7'(entries_used + 1);
            entries_used++;
         end
         queue_result(r);
      end else if (op == OP_QUERY) begin
         n = 0;
         for (int dx = -1; dx <= 1; dx++) begin
            for (int dy = -1; dy <= 1; dy++) begin
               for (int dz = -1; dz <= 1; dz++) begin
                  x = cx + dx;
                  y = cy + dy;
                  z = cz + dz;
                  if (x < 0 || y < 0 || z < 0 || x >= g || y >= g || z >= g) continue;
                  key = x + y * g + z * g * g;
                  if (key >= CELLS) continue;
                  link = head_of_cell[key];
                  while (link != 0 && link <= MAX_POINTS && n < MAX_POINTS) begin
                     queue_result('{KIND_NEIGH, value_of_entry[link-1], 1'b0});
                     n++;
                     link = link_of_entry[link-1];
                  end
               end
            end
         end
         if (n == 0) begin
            r.kind = KIND_NONE;
            queue_result(r);
         end else begin
            expected_q[$].last = 1'b1;
         end
      end else begin
         if (op == OP_CLEAR) begin
            foreach (head_of_cell[i]) head_of_cell[i] = '0;
            entries_used = 0;
         end
         queue_result(r);
      end
   endtask

   // Track register writes, predict on requests, compare on responses
   always @(posedge clock) begin
      result_type got, want;
      if (reset) begin
         inv_cell      <= INV_CELL_RESET;
         grid_side_reg <= GRID_DIM_RESET;
         foreach (head_of_cell[i]) head_of_cell[i] = '0;
         entries_used = 0;
         expected_q.delete();
      end else begin
         if (mon.csr_we) begin
            if (mon.csr_index == REG_INV_CELL) inv_cell <= mon.csr_wdata;
            else grid_side_reg <= mon.csr_wdata[4:0];
         end
         if (mon.req_fire)
            predict_neighbours(mon.opcode, mon.pos_x, mon.pos_y, mon.pos_z, mon.particle_index);
         if (mon.rsp_fire) begin
            got = '{mon.result_kind, mon.neighbour_index, mon.last};
            result_count++;
            if (expected_q.size() == 0) begin
               report("unexpected result", got, got);
            end else begin
               want = expected_q.pop_front();
               if (got.kind != want.kind) report("result_kind", got, want);
               else if (got.index != want.index) report("neighbour_index", got, want);
               else if (got.last != want.last) report("last", got, want);
            end
         end
      end
      pending_count = expected_q.size();
   end

   initial begin
      fail_count    = 0;
      result_count  = 0;
      pending_count = 0;
   end

endmodule

/* tb/grid_cell_neighbour_search_tb.sv */
`timescale 1ns / 100ps
// Testbench top: drives requests, register writes and response stalls, and gives the verdict.
module grid_cell_neighbour_search_tb import gcns_pkg::*; ();

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int MAX_POINTS_TB  = 64;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [0:0]       csr_index;
   logic [CSR_W-1:0] csr_wdata;
   int               fail_count;
   int               pending_count;
   int               result_count;
   int               request_count;
   int               idle_cycles;
   bit               stall_enable;

   gcns_req_if req_ch ();
   gcns_rsp_if rsp_ch ();
   gcns_mon_if mon ();

   grid_cell_neighbour_search DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch.sink),
      .rsp_ch    (rsp_ch.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   assign mon.req_fire        = req_ch.valid & req_ch.ready;
   assign mon.opcode          = req_ch.opcode;
   assign mon.pos_x           = req_ch.pos_x;
   assign mon.pos_y           = req_ch.pos_y;
   assign mon.pos_z           = req_ch.pos_z;
   assign mon.particle_index  = req_ch.particle_index;
   assign mon.rsp_fire        = rsp_ch.valid & rsp_ch.ready;
   assign mon.result_kind     = rsp_ch.result_kind;
   assign mon.neighbour_index = rsp_ch.neighbour_index;
   assign mon.last            = rsp_ch.last;
   assign mon.csr_we          = csr_we;
   assign mon.csr_index       = csr_index;
   assign mon.csr_wdata       = csr_wdata;

   gcns_scoreboard checker_inst (
      .clock         (clock),
      .reset         (reset),
      .mon           (mon),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Stall the receiver at random while stalls are enabled: ready in six of ten draws
   always @(negedge clock) begin
      if (!stall_enable) rsp_ch.ready <= 1'b1;
      else rsp_ch.ready <= ($urandom_range(0, 9) < 6);
   end

   // End the run when nothing is accepted for too long
   always @(posedge clock) begin
      if (reset || mon.req_fire || mon.rsp_fire || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending_count);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Send one request transaction, waiting for the handshake
   task automatic send_request(input logic [1:0] op, input logic [15:0] px,
                               input logic [15:0] py, input logic [15:0] pz,
                               input logic [5:0] pidx);
      req_ch.valid          <= 1'b1;
      req_ch.opcode         <= op;
      req_ch.pos_x          <= px;
      req_ch.pos_y          <= py;
      req_ch.pos_z          <= pz;
      req_ch.particle_index <= pidx;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      @(negedge clock);
      request_count++;
   endtask

   // Drop valid for a random gap now and then, giving bursts
   task automatic maybe_gap();
      int gap;
      if ($urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         gap = $urandom_range(1, 12);
         repeat (gap) @(negedge clock);
      end
   endtask

   // Wait until every expected result has arrived and the block is idle, then write
   task automatic write_register(input logic [0:0] idx, input logic [15:0] value);
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [15:0] rand_pos();
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   // Random requests in one setting: mostly inserts and queries, rarely a clear or a NOP
   task automatic random_phase(input int count);
      int sel;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 19);
         if (sel < 9)
            send_request(OP_INSERT, rand_pos(), rand_pos(), rand_pos(), 6'($urandom()));
         else if (sel < 17)
            send_request(OP_QUERY, rand_pos(), rand_pos(), rand_pos(), 6'($urandom()));
         else if (sel < 19)
            send_request(OP_CLEAR, rand_pos(), rand_pos(), rand_pos(), 6'($urandom()));
         else
            send_request(OP_NOP, rand_pos(), rand_pos(), rand_pos(), 6'($urandom()));
         maybe_gap();
      end
   endtask

   initial begin
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = REG_INV_CELL;
      csr_wdata             = '0;
      req_ch.valid          = 1'b0;
      req_ch.opcode         = OP_INSERT;
      req_ch.pos_x          = '0;
      req_ch.pos_y          = '0;
      req_ch.pos_z          = '0;
      req_ch.particle_index = '0;
      rsp_ch.ready          = 1'b1;
      stall_enable          = 1'b0;
      request_count         = 0;
      idle_cycles           = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty query, corners, every opcode, edge cells
      send_request(OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 6'd0);
      send_request(OP_INSERT, 16'h0000, 16'h0000, 16'h0000, 6'd63);
      send_request(OP_INSERT, 16'h0000, 16'h0000, 16'h0000, 6'd0);
      send_request(OP_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd42);
      send_request(OP_INSERT, 16'h0100, 16'h0000, 16'h0000, 6'd21);
      send_request(OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 6'd0);
      send_request(OP_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd0);
      send_request(OP_QUERY, 16'h0800, 16'h0800, 16'h0800, 6'd0);
      send_request(OP_NOP, 16'h1234, 16'h5678, 16'h9ABC, 6'd7);
      send_request(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 6'd0);
      send_request(OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 6'd0);

      // Fill the store in one cell, then overflow it
      write_register(REG_GRID_DIM, 16'd2);
      for (int i = 0; i < MAX_POINTS_TB; i++)
         send_request(OP_INSERT, 16'h0000, 16'h0000, 16'h0000, 6'(i));
      send_request(OP_INSERT, 16'hFFFF, 16'h0000, 16'h0000, 6'd1);
      send_request(OP_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd0);
      send_request(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 6'd0);

      // Random phases over several settings, extremes included
      stall_enable = 1'b1;
      write_register(REG_GRID_DIM, 16'd0);
      write_register(REG_INV_CELL, 16'd1);
      random_phase(10);
      write_register(REG_GRID_DIM, 16'd16);
      write_register(REG_INV_CELL, 16'hFFFF);
      random_phase(20);
      write_register(REG_INV_CELL, 16'd256);
      random_phase(25);
      write_register(REG_GRID_DIM, 16'd31);
      write_register(REG_INV_CELL, 16'h0040);
      random_phase(15);
      write_register(REG_GRID_DIM, 16'd5);
      write_register(REG_INV_CELL, 16'h0010);
      random_phase(12);
      stall_enable = 1'b0;
      write_register(REG_GRID_DIM, 16'd3);
      write_register(REG_INV_CELL, 16'h0055);
      random_phase(10);

      // Drain and let the block settle
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (50) @(negedge clock);

      $display("Sent %0d requests and checked %0d results across several grid settings,",
               request_count, result_count);
      $display("including full store, empty queries and grid edges; %0d mismatches.",
               fail_count);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
src/gcns_pkg.sv
src/gcns_if.sv
src/gcns_ram.sv
src/grid_cell_neighbour_search.sv
src/gcns_checker.sv
tb/gcns_tb_if.sv
tb/gcns_checker.sv
tb/grid_cell_neighbour_search_tb.sv
